// ===== rtl/cbaf_pkg.sv =====
`default_nettype none
// Package for the adaptive cubic Bezier flattener: widths, sequencer states,
// operand table for the flatness products and the fixed-point helper functions.
// No dependencies.

package cbaf_pkg;

    // Subdivision depth and input format.
    localparam int MAX_DEPTH       = 6;
    localparam int COORD_FRAC_BITS = 8;
    localparam int IN_W            = 24;
    localparam int LIMIT_W         = 40;
    localparam int PIX_W           = 16;

    // Internal coordinate format: MAX_DEPTH extra fraction bits; halfsum floors midpoints beyond them.
    localparam int INT_W    = IN_W + MAX_DEPTH;
    localparam int INT_FRAC = COORD_FRAC_BITS + MAX_DEPTH;
    localparam int RND_W    = INT_W - INT_FRAC + 1;
    localparam int N_COORD  = 8;

    // Flatness arithmetic widths.
    localparam int DIFF_W  = INT_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int ACC_W   = CROSS_W + 2;
    localparam int LIMIT_SHIFT = 2 * MAX_DEPTH;

    // Stack of waiting halves: one row holds eight coordinates and a level.
    localparam int STACK_DEPTH = MAX_DEPTH;
    localparam int LEVEL_W     = $clog2(MAX_DEPTH + 1);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int ROW_W       = N_COORD * INT_W + LEVEL_W;

    // Flatness pass schedule: eight products through one multiplier.
    localparam int PRODUCTS  = 8;
    localparam int ACC_FIRST = 4;
    localparam int ACC_LAST  = PRODUCTS + 2;
    localparam int FLAT_LAST = PRODUCTS + 3;
    localparam int CNT_W     = $clog2(FLAT_LAST + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(262144);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLAT,
        ST_SPLIT1,
        ST_SPLIT2,
        ST_SPLIT3,
        ST_EMIT,
        ST_POP
    } state_t;

    // Control-point differences used by the cross products.
    typedef enum logic [3:0] {
        D_VX0,
        D_VY0,
        D_VX1,
        D_VY1,
        D_VX2,
        D_VY2,
        D_VX3,
        D_VY3,
        D_VX4,
        D_VY4
    } diff_sel_t;

    localparam int DIFF_N = 10;

    typedef struct packed {
        diff_sel_t a;
        diff_sel_t b;
    } op_pair_t;

    // Operand pair of each product; products come in pairs whose difference is one cross term.
    function automatic op_pair_t op_pair(input logic [2:0] j);
        op_pair_t p;
        case (j)
            3'd0: p = '{a: D_VX0, b: D_VY1};
            3'd1: p = '{a: D_VY0, b: D_VX1};
            3'd2: p = '{a: D_VX1, b: D_VY2};
            3'd3: p = '{a: D_VY1, b: D_VX2};
            3'd4: p = '{a: D_VX3, b: D_VY4};
            3'd5: p = '{a: D_VY3, b: D_VX4};
            3'd6: p = '{a: D_VX0, b: D_VY4};
            3'd7: p = '{a: D_VY0, b: D_VX4};
            default: p = '{a: D_VX0, b: D_VY1};
        endcase
        return p;
    endfunction

    // Midpoint rounded toward minus infinity.
    function automatic logic signed [INT_W-1:0] halfsum(
        input logic signed [INT_W-1:0] a,
        input logic signed [INT_W-1:0] b
    );
        logic signed [INT_W:0] s;
        s = (INT_W+1)'(a) + (INT_W+1)'(b);
        return s[INT_W:1];
    endfunction

    // Round half away from zero to whole pixels and saturate.
    function automatic logic [PIX_W-1:0] to_pixel(input logic signed [INT_W-1:0] v);
        logic [INT_W:0]   t;
        logic [RND_W-1:0] r;
        logic [PIX_W-1:0] p;
        if (v[INT_W-1])
        begin
            t = (INT_W+1)'(1 << (INT_FRAC - 1)) - (INT_W+1)'(v);
        end
        else
        begin
            t = (INT_W+1)'(v) + (INT_W+1)'(1 << (INT_FRAC - 1));
        end
        r = t[INT_W:INT_FRAC];
        if (v[INT_W-1])
        begin
            if (r > RND_W'(1 << (PIX_W - 1)))
            begin
                p = {1'b1, {(PIX_W-1){1'b0}}};
            end
            else
            begin
                p = PIX_W'(RND_W'(0) - r);
            end
        end
        else
        begin
            if (r > RND_W'((1 << (PIX_W - 1)) - 1))
            begin
                p = {1'b0, {(PIX_W-1){1'b1}}};
            end
            else
            begin
                p = PIX_W'(r);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cbaf_ram.sv =====
`default_nettype none
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module cbaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/cubic_bezier_adaptive_flattener.sv =====
`default_nettype none
// Top level of the adaptive cubic Bezier flattener: sequencer, shared flatness
// multiplier, de Casteljau halving and the stack of waiting halves.
// Depends on cbaf_pkg and cbaf_ram.
//
//  Channel   | Handshake                     | Payload
//  ----------+-------------------------------+-------------------------------------
//  config    | flatness_limit_we             | flatness_limit_wdata (40 bits)
//  curve in  | start, busy (beat: start&!busy)| start_x .. end_y (8 x 24-bit signed)
//  leaf out  | leaf_valid (one-cycle strobe) | leaf_p0_x .. leaf_p3_y, last_leaf,
//            |                               | depth_capped
//
// Each flatness test runs its products through the one 31x31 multiplier; each halving
// steps through ST_SPLIT1 to ST_SPLIT3, each leaf beat is an ST_EMIT state and each stack pop
// waits in ST_POP for the registered RAM read.
// Leaf beats never come in consecutive cycles; the last leaf appears as busy falls.
// Reset clears the sequencer, the stack count and the limit (262144); the stack RAM is not cleared.
// The receiver cannot stall the leaf output.

module cubic_bezier_adaptive_flattener (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              flatness_limit_we,
    input  logic [cbaf_pkg::LIMIT_W-1:0]      flatness_limit_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [cbaf_pkg::IN_W-1:0]  start_x,
    input  logic signed [cbaf_pkg::IN_W-1:0]  start_y,
    input  logic signed [cbaf_pkg::IN_W-1:0]  ctrl_a_x,
    input  logic signed [cbaf_pkg::IN_W-1:0]  ctrl_a_y,
    input  logic signed [cbaf_pkg::IN_W-1:0]  ctrl_b_x,
    input  logic signed [cbaf_pkg::IN_W-1:0]  ctrl_b_y,
    input  logic signed [cbaf_pkg::IN_W-1:0]  end_x,
    input  logic signed [cbaf_pkg::IN_W-1:0]  end_y,
    output logic                              leaf_valid,
    output logic signed [cbaf_pkg::PIX_W-1:0] leaf_p0_x,
    output logic signed [cbaf_pkg::PIX_W-1:0] leaf_p0_y,
    output logic signed [cbaf_pkg::PIX_W-1:0] leaf_p1_x,
    output logic signed [cbaf_pkg::PIX_W-1:0] leaf_p1_y,
    output logic signed [cbaf_pkg::PIX_W-1:0] leaf_p2_x,
    output logic signed [cbaf_pkg::PIX_W-1:0] leaf_p2_y,
    output logic signed [cbaf_pkg::PIX_W-1:0] leaf_p3_x,
    output logic signed [cbaf_pkg::PIX_W-1:0] leaf_p3_y,
    output logic                              last_leaf,
    output logic                              depth_capped
);

    // Control state.
    cbaf_pkg::state_t                 state_reg, state_next;
    logic [cbaf_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [cbaf_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [cbaf_pkg::LEVEL_W-1:0]     level_reg, level_next;
    logic                             flat_reg;
    logic [cbaf_pkg::LIMIT_W-1:0]     limit_reg;
    logic                             leaf_valid_reg;

    // Working curve and datapath registers.
    logic signed [cbaf_pkg::INT_W-1:0]   wc_reg [cbaf_pkg::N_COORD];
    logic signed [cbaf_pkg::DIFF_W-1:0]  op_a_reg, op_b_reg;
    logic signed [cbaf_pkg::PROD_W-1:0]  prod_reg, pend_reg;
    logic signed [cbaf_pkg::CROSS_W-1:0] cross_reg;
    logic [cbaf_pkg::ACC_W-1:0]          acc_reg;
    logic signed [cbaf_pkg::INT_W-1:0]   m01_reg [2];
    logic signed [cbaf_pkg::INT_W-1:0]   m12_reg [2];
    logic signed [cbaf_pkg::INT_W-1:0]   m23_reg [2];
    logic signed [cbaf_pkg::INT_W-1:0]   sa_reg  [2];
    logic signed [cbaf_pkg::INT_W-1:0]   sb_reg  [2];
    logic [cbaf_pkg::PIX_W-1:0]          pix_reg [cbaf_pkg::N_COORD];
    logic                                last_reg;
    logic                                capped_reg;

    // Combinational signals.
    logic signed [cbaf_pkg::IN_W-1:0]    in_pt [cbaf_pkg::N_COORD];
    logic signed [cbaf_pkg::DIFF_W-1:0]  diff  [cbaf_pkg::DIFF_N];
    logic signed [cbaf_pkg::INT_W-1:0]   mid   [2];
    cbaf_pkg::op_pair_t                  sel;
    logic signed [cbaf_pkg::PROD_W-1:0]  prod_full;
    logic signed [cbaf_pkg::CROSS_W-1:0] cross_full;
    logic [cbaf_pkg::ACC_W-1:0]          cross_ext;
    logic [cbaf_pkg::ACC_W-1:0]          acc_sum;
    logic [cbaf_pkg::ACC_W-1:0]          limit_ext;
    logic                                flat_now;
    logic                                split_go;
    logic                                flat_done;
    logic                                acc_add;
    logic                                load_in;
    logic                                flat_run;
    logic                                do_split1;
    logic                                do_split2;
    logic                                do_split3;
    logic                                do_emit;
    logic                                do_pop;
    logic [cbaf_pkg::ROW_W-1:0]          push_row;
    logic [cbaf_pkg::ROW_W-1:0]          pop_row;
    logic [cbaf_pkg::ADDR_W-1:0]         ram_waddr;
    logic [cbaf_pkg::ADDR_W-1:0]         ram_raddr;
    logic [cbaf_pkg::COUNT_W-1:0]        count_dec;

    assign in_pt[0] = start_x;
    assign in_pt[1] = start_y;
    assign in_pt[2] = ctrl_a_x;
    assign in_pt[3] = ctrl_a_y;
    assign in_pt[4] = ctrl_b_x;
    assign in_pt[5] = ctrl_b_y;
    assign in_pt[6] = end_x;
    assign in_pt[7] = end_y;

    // Flatness decision from the finished accumulator.
    assign limit_ext = cbaf_pkg::ACC_W'({limit_reg, {cbaf_pkg::LIMIT_SHIFT{1'b0}}});
    assign flat_now  = acc_reg < limit_ext;
    assign flat_done = (state_reg == cbaf_pkg::ST_FLAT)
                     && (cnt_reg == cbaf_pkg::CNT_W'(cbaf_pkg::FLAT_LAST));
    assign split_go  = !flat_now
                     && (level_reg < cbaf_pkg::LEVEL_W'(cbaf_pkg::MAX_DEPTH))
                     && (count_reg < cbaf_pkg::COUNT_W'(cbaf_pkg::STACK_DEPTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbaf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cbaf_pkg::ST_FLAT;
                end
            end
            cbaf_pkg::ST_FLAT:
            begin
                if (flat_done)
                begin
                    state_next = split_go ? cbaf_pkg::ST_SPLIT1 : cbaf_pkg::ST_EMIT;
                end
            end
            cbaf_pkg::ST_SPLIT1: state_next = cbaf_pkg::ST_SPLIT2;
            cbaf_pkg::ST_SPLIT2: state_next = cbaf_pkg::ST_SPLIT3;
            cbaf_pkg::ST_SPLIT3: state_next = cbaf_pkg::ST_FLAT;
            cbaf_pkg::ST_EMIT:
            begin
                if (count_reg == '0)
                begin
                    state_next = cbaf_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = cbaf_pkg::ST_POP;
                end
            end
            cbaf_pkg::ST_POP: state_next = cbaf_pkg::ST_FLAT;
            default: state_next = cbaf_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        load_in   = 1'b0;
        flat_run  = 1'b0;
        do_split1 = 1'b0;
        do_split2 = 1'b0;
        do_split3 = 1'b0;
        do_emit   = 1'b0;
        do_pop    = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            cbaf_pkg::ST_IDLE:
            begin
                busy    = 1'b0;
                load_in = start;
            end
            cbaf_pkg::ST_FLAT:   flat_run  = 1'b1;
            cbaf_pkg::ST_SPLIT1: do_split1 = 1'b1;
            cbaf_pkg::ST_SPLIT2: do_split2 = 1'b1;
            cbaf_pkg::ST_SPLIT3: do_split3 = 1'b1;
            cbaf_pkg::ST_EMIT:   do_emit   = 1'b1;
            cbaf_pkg::ST_POP:    do_pop    = 1'b1;
            default:             busy      = 1'b0;
        endcase
    end

    // Step counter, stack count and level.
    assign count_dec = count_reg - cbaf_pkg::COUNT_W'(1);

    always_comb
    begin
        cnt_next   = flat_run ? cnt_reg + cbaf_pkg::CNT_W'(1) : '0;
        count_next = count_reg;
        level_next = level_reg;
        if (load_in)
        begin
            count_next = '0;
            level_next = '0;
        end
        else if (do_split3)
        begin
            count_next = count_reg + cbaf_pkg::COUNT_W'(1);
            level_next = level_reg + cbaf_pkg::LEVEL_W'(1);
        end
        else if (do_emit && (count_reg != '0))
        begin
            count_next = count_dec;
        end
        else if (do_pop)
        begin
            level_next = pop_row[cbaf_pkg::N_COORD*cbaf_pkg::INT_W +: cbaf_pkg::LEVEL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cbaf_pkg::ST_IDLE;
            cnt_reg        <= '0;
            count_reg      <= '0;
            level_reg      <= '0;
            flat_reg       <= 1'b0;
            limit_reg      <= cbaf_pkg::LIMIT_RESET;
            leaf_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            count_reg      <= count_next;
            level_reg      <= level_next;
            leaf_valid_reg <= do_emit;
            if (flat_done)
            begin
                flat_reg <= flat_now;
            end
            if (flatness_limit_we)
            begin
                limit_reg <= flatness_limit_wdata;
            end
        end
    end

    // Control-point differences, each at a fixed place in the curve.
    always_comb
    begin
        diff[cbaf_pkg::D_VX0] = cbaf_pkg::DIFF_W'(wc_reg[2]) - cbaf_pkg::DIFF_W'(wc_reg[0]);
        diff[cbaf_pkg::D_VY0] = cbaf_pkg::DIFF_W'(wc_reg[3]) - cbaf_pkg::DIFF_W'(wc_reg[1]);
        diff[cbaf_pkg::D_VX1] = cbaf_pkg::DIFF_W'(wc_reg[4]) - cbaf_pkg::DIFF_W'(wc_reg[2]);
        diff[cbaf_pkg::D_VY1] = cbaf_pkg::DIFF_W'(wc_reg[5]) - cbaf_pkg::DIFF_W'(wc_reg[3]);
        diff[cbaf_pkg::D_VX2] = cbaf_pkg::DIFF_W'(wc_reg[6]) - cbaf_pkg::DIFF_W'(wc_reg[4]);
        diff[cbaf_pkg::D_VY2] = cbaf_pkg::DIFF_W'(wc_reg[7]) - cbaf_pkg::DIFF_W'(wc_reg[5]);
        diff[cbaf_pkg::D_VX3] = cbaf_pkg::DIFF_W'(wc_reg[4]) - cbaf_pkg::DIFF_W'(wc_reg[0]);
        diff[cbaf_pkg::D_VY3] = cbaf_pkg::DIFF_W'(wc_reg[5]) - cbaf_pkg::DIFF_W'(wc_reg[1]);
        diff[cbaf_pkg::D_VX4] = cbaf_pkg::DIFF_W'(wc_reg[6]) - cbaf_pkg::DIFF_W'(wc_reg[0]);
        diff[cbaf_pkg::D_VY4] = cbaf_pkg::DIFF_W'(wc_reg[7]) - cbaf_pkg::DIFF_W'(wc_reg[1]);
    end

    // Shared multiplier pipeline: operands, product, cross term, accumulate.
    assign sel        = cbaf_pkg::op_pair(cnt_reg[2:0]);
    assign prod_full  = cbaf_pkg::PROD_W'(op_a_reg) * cbaf_pkg::PROD_W'(op_b_reg);
    assign cross_full = cbaf_pkg::CROSS_W'(pend_reg) - cbaf_pkg::CROSS_W'(prod_reg);
    assign cross_ext  = cbaf_pkg::ACC_W'(cross_reg);
    assign acc_sum    = acc_reg + (cross_ext ^ {cbaf_pkg::ACC_W{cross_reg[cbaf_pkg::CROSS_W-1]}})
                      + cbaf_pkg::ACC_W'(cross_reg[cbaf_pkg::CROSS_W-1]);
    assign acc_add    = (cnt_reg >= cbaf_pkg::CNT_W'(cbaf_pkg::ACC_FIRST))
                      && (cnt_reg <= cbaf_pkg::CNT_W'(cbaf_pkg::ACC_LAST)) && !cnt_reg[0];

    always_ff @(posedge clk)
    begin
        if (flat_run)
        begin
            op_a_reg <= diff[sel.a];
            op_b_reg <= diff[sel.b];
            prod_reg <= prod_full;
            // Even products wait for their partner; odd ones close a cross term.
            if (!cnt_reg[0])
            begin
                pend_reg <= prod_reg;
            end
            else
            begin
                cross_reg <= cross_full;
            end
            if (cnt_reg == '0)
            begin
                acc_reg <= '0;
            end
            else if (acc_add)
            begin
                acc_reg <= acc_sum;
            end
        end
    end

    // De Casteljau halving, one midpoint level per cycle, both axes in parallel.
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            mid[k] = cbaf_pkg::halfsum(sa_reg[k], sb_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            if (do_split1)
            begin
                m01_reg[k] <= cbaf_pkg::halfsum(wc_reg[k], wc_reg[2+k]);
                m12_reg[k] <= cbaf_pkg::halfsum(wc_reg[2+k], wc_reg[4+k]);
                m23_reg[k] <= cbaf_pkg::halfsum(wc_reg[4+k], wc_reg[6+k]);
            end
            if (do_split2)
            begin
                sa_reg[k] <= cbaf_pkg::halfsum(m01_reg[k], m12_reg[k]);
                sb_reg[k] <= cbaf_pkg::halfsum(m12_reg[k], m23_reg[k]);
            end
        end
    end

    // Stack row of the second half and its level.
    always_comb
    begin
        push_row = '0;
        for (int k = 0; k < 2; k++)
        begin
            push_row[k*cbaf_pkg::INT_W +: cbaf_pkg::INT_W]     = mid[k];
            push_row[(2+k)*cbaf_pkg::INT_W +: cbaf_pkg::INT_W] = sb_reg[k];
            push_row[(4+k)*cbaf_pkg::INT_W +: cbaf_pkg::INT_W] = m23_reg[k];
            push_row[(6+k)*cbaf_pkg::INT_W +: cbaf_pkg::INT_W] = wc_reg[6+k];
        end
        push_row[cbaf_pkg::N_COORD*cbaf_pkg::INT_W +: cbaf_pkg::LEVEL_W] =
            level_reg + cbaf_pkg::LEVEL_W'(1);
    end

    assign ram_waddr = count_reg[cbaf_pkg::ADDR_W-1:0];
    assign ram_raddr = count_dec[cbaf_pkg::ADDR_W-1:0];

    cbaf_ram #(
        .WIDTH (cbaf_pkg::ROW_W),
        .DEPTH (cbaf_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (do_split3),
        .waddr (ram_waddr),
        .wdata (push_row),
        .raddr (ram_raddr),
        .rdata (pop_row)
    );

    // Working curve: loaded from the input, replaced by the first half, or popped.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < cbaf_pkg::N_COORD; i++)
        begin
            if (load_in)
            begin
                wc_reg[i] <= {in_pt[i], {cbaf_pkg::MAX_DEPTH{1'b0}}};
            end
            else if (do_pop)
            begin
                wc_reg[i] <= pop_row[i*cbaf_pkg::INT_W +: cbaf_pkg::INT_W];
            end
        end
        if (do_split3)
        begin
            for (int k = 0; k < 2; k++)
            begin
                wc_reg[2+k] <= m01_reg[k];
                wc_reg[4+k] <= sa_reg[k];
                wc_reg[6+k] <= mid[k];
            end
        end
    end

    // Leaf output register.
    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            for (int i = 0; i < cbaf_pkg::N_COORD; i++)
            begin
                pix_reg[i] <= cbaf_pkg::to_pixel(wc_reg[i]);
            end
            last_reg   <= (count_reg == '0);
            capped_reg <= !flat_reg;
        end
    end

    assign leaf_valid   = leaf_valid_reg;
    assign leaf_p0_x    = pix_reg[0];
    assign leaf_p0_y    = pix_reg[1];
    assign leaf_p1_x    = pix_reg[2];
    assign leaf_p1_y    = pix_reg[3];
    assign leaf_p2_x    = pix_reg[4];
    assign leaf_p2_y    = pix_reg[5];
    assign leaf_p3_x    = pix_reg[6];
    assign leaf_p3_y    = pix_reg[7];
    assign last_leaf    = last_reg;
    assign depth_capped = capped_reg;

endmodule

`default_nettype wire

// ===== rtl/cbaf_checker.sv =====
`default_nettype none
// Port-level checker for the adaptive cubic Bezier flattener, bound to the top level.
// Depends on cubic_bezier_adaptive_flattener.

module cbaf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic leaf_valid,
    input logic last_leaf
);

    // An accepted curve makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted curve");

    // A leaf beat only follows a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n) leaf_valid |-> $past(busy))
        else $error("leaf beat without work in progress");

    // The last leaf comes out as busy falls; other leaves while still busy.
    assert property (@(posedge clk) disable iff (!rst_n) leaf_valid |-> (busy == !last_leaf))
        else $error("last_leaf does not match the end of the curve");

    // Leaf beats never come in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n) leaf_valid |=> !leaf_valid)
        else $error("leaf beats in consecutive cycles");

endmodule

bind cubic_bezier_adaptive_flattener cbaf_checker u_cbaf_checker (.*);

`default_nettype wire
